>>> hw/rtl/dmap_pkg.sv
// ----------------------------------------------------------------------------
// DMAP parser package
// Shared constants, field kinds and the tag-to-kind lookup.
// ----------------------------------------------------------------------------
package dmap_pkg;

   // Field kinds, also used as element classes while a length is read.
   localparam logic [3:0] KIND_REC   = 4'd0;
   localparam logic [3:0] KIND_BYTE  = 4'd1;
   localparam logic [3:0] KIND_SHORT = 4'd2;
   localparam logic [3:0] KIND_INT   = 4'd3;
   localparam logic [3:0] KIND_LONG  = 4'd4;
   localparam logic [3:0] KIND_DATE  = 4'd5;
   localparam logic [3:0] KIND_VER   = 4'd6;
   localparam logic [3:0] KIND_STR   = 4'd7;
   localparam logic [3:0] KIND_END   = 4'd8;
   localparam logic [3:0] KIND_LIST  = 4'd9;
   localparam logic [3:0] KIND_ITEM  = 4'd10;
   localparam logic [3:0] KIND_NONE  = 4'd0;

   // Tag table groups.
   localparam logic [2:0] GRP_TOP  = 3'd0;
   localparam logic [2:0] GRP_ITEM = 3'd1;
   localparam logic [2:0] GRP_SRV  = 3'd2;
   localparam logic [2:0] GRP_LOG  = 3'd3;
   localparam logic [2:0] GRP_UPD  = 3'd4;

   // Response modes.
   localparam logic [2:0] MODE_NONE = 3'd0;
   localparam logic [2:0] MODE_SRV  = 3'd1;
   localparam logic [2:0] MODE_LOG  = 3'd2;
   localparam logic [2:0] MODE_UPD  = 3'd3;
   localparam logic [2:0] MODE_LIST = 3'd4;

   // Parse status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [1:0] STAT_TRUNC   = 2'd2;
   localparam logic [1:0] STAT_UNSUPP  = 2'd3;

   // Byte phases.
   localparam logic [3:0] PH_RTAG = 4'd0;
   localparam logic [3:0] PH_RLEN = 4'd1;
   localparam logic [3:0] PH_TAG  = 4'd2;
   localparam logic [3:0] PH_LEN  = 4'd3;
   localparam logic [3:0] PH_NUM  = 4'd3;
   localparam logic [3:0] PH_STR  = 4'd10;

   localparam int unsigned BYTE_W = 8;

   // One queued input word.
   typedef struct packed {
      logic                last;
      logic [BYTE_W-1:0]   data;
   } in_word_type;

   // One result word.
   typedef struct packed {
      logic [31:0] tag;
      logic [3:0]  kind;
      logic [63:0] value;
      logic        done;
      logic        empty;
      logic        in_record;
      logic        final_flag;
      logic [1:0]  status;
   } rsp_word_type;

   // Element kind of a tag within a group; KIND_NONE when not found.
   function automatic logic [3:0] tag_lookup(input logic [2:0] grp, input logic [31:0] tag);
      logic [3:0] k;
      k = KIND_NONE;
      unique case (grp)
         GRP_TOP: begin
            unique case (tag)
               "mstt", "mtco", "mrco": k = KIND_INT;
               "muty":                 k = KIND_BYTE;
               "mlcl":                 k = KIND_LIST;
               default:                k = KIND_NONE;
            endcase
         end
         GRP_ITEM: begin
            unique case (tag)
               "miid", "assr", "assz", "asst", "assp", "astm", "mcti", "mudl",
               "mimc", "mctc":                              k = KIND_INT;
               "mper":                                      k = KIND_LONG;
               "minm", "asul", "asal", "asar", "ascm", "asgn", "asfm", "asdt",
               "ascp", "agrp":                              k = KIND_STR;
               "mikd", "asdk", "asco", "aeSP", "abpl":      k = KIND_BYTE;
               "asbr", "asyr", "astn", "astc", "asdc", "asdn", "asbt":
                                                            k = KIND_SHORT;
               "asda", "asdm":                              k = KIND_DATE;
               default:                                     k = KIND_NONE;
            endcase
         end
         GRP_SRV: begin
            unique case (tag)
               "mstt", "mstm", "aeSV", "msdc":              k = KIND_INT;
               "apro", "mpro":                              k = KIND_VER;
               "msix", "msex", "msup", "msal", "mslr", "msqy", "msrs", "msbr",
               "mspi", "msas", "msau":                      k = KIND_BYTE;
               "minm":                                      k = KIND_STR;
               default:                                     k = KIND_NONE;
            endcase
         end
         GRP_LOG: begin
            unique case (tag)
               "mstt", "mlid": k = KIND_INT;
               default:        k = KIND_NONE;
            endcase
         end
         GRP_UPD: begin
            unique case (tag)
               "musr", "mstt": k = KIND_INT;
               default:        k = KIND_NONE;
            endcase
         end
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

>>> hw/rtl/dmap_tlv_stream_parser.sv
// The byte that causes a result is first held in the input queue; the core then
// takes it from the queue and registers the result.
// Throughput: one byte per cycle while no untaken result stalls the core's phase machine.
// A two-word input queue lets the input side run while a result waits.
// Reset is synchronous and active high; it empties the queue and result register
// and returns the parser to the response header.
// ----------------------------------------------------------------------------
// DMAP TLV stream parser
// Parses a DMAP response byte stream into typed field words.
// ----------------------------------------------------------------------------
module dmap_tlv_stream_parser (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,  // data_byte[7:0]
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tag_code[31:0], field_value[95:32], string_done[96], string_empty[97],
   // inside_record[98], parse_status[100:99], zero fill [103:101]
   output logic [103:0]  rsp_tdata,
   output logic [3:0]    rsp_tuser,  // field_kind[3:0]
   output logic          rsp_tlast
);
   import dmap_pkg::*;

   in_word_type  push_word, pop_word;
   logic         pop_valid, pop_ready;
   rsp_word_type rsp_word;

   assign push_word.data = req_tdata;
   assign push_word.last = req_tlast;

   // Front: input queue.
   dmap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   // Back: parser core with result register.
   dmap_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_word   (pop_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   // Result word packing.
   assign rsp_tdata = {3'd0, rsp_word.status, rsp_word.in_record, rsp_word.empty,
                       rsp_word.done, rsp_word.value, rsp_word.tag};
   assign rsp_tuser = rsp_word.kind;
   assign rsp_tlast = rsp_word.final_flag;

endmodule

>>> hw/rtl/dmap_queue.sv
// ----------------------------------------------------------------------------
// DMAP input queue
// Two-entry queue that accepts input words and decouples the parser core.
// ----------------------------------------------------------------------------
module dmap_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  dmap_pkg::in_word_type push_word,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output dmap_pkg::in_word_type pop_word
);
   import dmap_pkg::*;

   in_word_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   // Handshake and pointer updates.
   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_word   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> hw/rtl/dmap_core.sv
// ----------------------------------------------------------------------------
// DMAP parser core
// Runs the byte phase machine on queued words and holds the result register.
// ----------------------------------------------------------------------------
module dmap_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dmap_pkg::in_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dmap_pkg::rsp_word_type out_word
);
   import dmap_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] left_ff, left_in;
   logic [2:0]  mode_ff, mode_in;
   logic [1:0]  nest_ff, nest_in;
   logic        halt_ff, halt_in;
   logic        valid_ff, valid_in;
   rsp_word_type rsp_ff, rsp_in;

   logic        step, have, stop, last;
   logic [7:0]  b;
   logic [31:0] tag_next, left_inc, len_next;
   logic [3:0]  k, k_item;
   logic [1:0]  lvl;
   logic [63:0] acc_next;

   assign in_ready  = !valid_ff || out_ready;
   assign step      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_word  = rsp_ff;
   assign b         = in_word.data;
   assign last      = in_word.last;

   // Phase machine for one byte.
   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      mode_in  = mode_ff;
      nest_in  = nest_ff;
      halt_in  = halt_ff;
      have     = 1'b0;
      stop     = 1'b0;
      rsp_in   = '0;
      k        = KIND_NONE;
      k_item   = KIND_NONE;
      lvl      = nest_ff;
      tag_next = (left_ff == 32'd0) ? {24'd0, b} : {tag_ff[23:0], b};
      left_inc = left_ff + 32'd1;
      len_next = {len_ff[23:0], b};
      acc_next = {acc_ff[55:0], b};

      if (halt_ff) begin
         // Ignore bytes until the buffer ends.
         if (last) begin
            phase_in = PH_RTAG;
            tag_in   = '0;
            len_in   = '0;
            acc_in   = '0;
            left_in  = '0;
            mode_in  = MODE_NONE;
            nest_in  = 2'd0;
            halt_in  = 1'b0;
         end
      end else begin
         priority case (1'b1)
            phase_ff == PH_RTAG: begin
               tag_in  = tag_next;
               left_in = left_inc;
               if (left_inc >= 32'd4) begin
                  left_in = '0;
                  if (tag_next == "msrv")      mode_in = MODE_SRV;
                  else if (tag_next == "mlog") mode_in = MODE_LOG;
                  else if (tag_next == "mupd") mode_in = MODE_UPD;
                  else if (tag_next == "adbs" || tag_next == "avdb" ||
                           tag_next == "apso" || tag_next == "aply")
                     mode_in = MODE_LIST;
                  else mode_in = MODE_NONE;
                  if (mode_in == MODE_NONE) begin
                     have          = 1'b1;
                     stop          = 1'b1;
                     rsp_in.tag    = tag_next;
                     rsp_in.kind   = KIND_END;
                     rsp_in.status = STAT_UNSUPP;
                  end else begin
                     phase_in = PH_RLEN;
                  end
               end
            end
            phase_ff == PH_RLEN: begin
               left_in = left_inc;
               if (left_inc >= 32'd4) begin
                  left_in  = '0;
                  phase_in = PH_TAG;
               end
            end
            phase_ff == PH_LEN: begin
               len_in  = len_next;
               left_in = left_inc;
               if (left_inc >= 32'd4) begin
                  k        = acc_ff[3:0];
                  acc_in   = '0;
                  left_in  = '0;
                  phase_in = PH_TAG;
                  if (acc_ff[63:4] != 60'd0) begin
                     // Class field never exceeds four bits.
                     k = KIND_NONE;
                  end else if (k == KIND_LIST || k == KIND_ITEM) begin
                     have             = 1'b1;
                     rsp_in.tag       = tag_ff;
                     rsp_in.kind      = KIND_REC;
                     rsp_in.in_record = (k == KIND_ITEM);
                  end else if (k == KIND_STR) begin
                     if (len_next == 32'd0) begin
                        have             = 1'b1;
                        rsp_in.tag       = tag_ff;
                        rsp_in.kind      = KIND_STR;
                        rsp_in.done      = 1'b1;
                        rsp_in.empty     = 1'b1;
                        rsp_in.in_record = nest_ff[1];
                     end else begin
                        left_in  = len_next;
                        phase_in = PH_STR;
                     end
                  end else if (k >= KIND_BYTE && k <= KIND_VER) begin
                     unique case (k)
                        KIND_BYTE:  left_in = 32'd1;
                        KIND_SHORT: left_in = 32'd2;
                        KIND_LONG:  left_in = 32'd8;
                        default:    left_in = 32'd4;
                     endcase
                     phase_in = PH_NUM + k;
                  end
               end
            end
            (phase_ff >= PH_NUM + KIND_BYTE) && (phase_ff <= PH_NUM + KIND_VER): begin
               acc_in  = acc_next;
               left_in = (left_ff != 32'd0) ? left_ff - 32'd1 : left_ff;
               if (left_in == 32'd0) begin
                  have             = 1'b1;
                  rsp_in.tag       = tag_ff;
                  rsp_in.kind      = phase_ff - PH_NUM;
                  rsp_in.value     = acc_next;
                  rsp_in.in_record = nest_ff[1];
                  acc_in           = '0;
                  phase_in         = PH_TAG;
               end
            end
            phase_ff == PH_STR: begin
               have             = 1'b1;
               left_in          = (left_ff != 32'd0) ? left_ff - 32'd1 : left_ff;
               rsp_in.tag       = tag_ff;
               rsp_in.kind      = KIND_STR;
               rsp_in.value     = {56'd0, b};
               rsp_in.done      = (left_in == 32'd0);
               rsp_in.in_record = nest_ff[1];
               if (left_in == 32'd0) phase_in = PH_TAG;
            end
            default: begin
               // Element tag collection and classification.
               phase_in = PH_TAG;
               tag_in   = tag_next;
               left_in  = left_inc;
               if (left_inc >= 32'd4) begin
                  left_in = '0;
                  unique case (mode_ff)
                     MODE_SRV: k = tag_lookup(GRP_SRV, tag_next);
                     MODE_LOG: k = tag_lookup(GRP_LOG, tag_next);
                     MODE_UPD: k = tag_lookup(GRP_UPD, tag_next);
                     MODE_LIST: begin
                        k_item = tag_lookup(GRP_ITEM, tag_next);
                        if (nest_ff != 2'd0 && tag_next == "mlit") begin
                           lvl = 2'd2;
                           k   = KIND_ITEM;
                        end else if (nest_ff >= 2'd2 && k_item != KIND_NONE) begin
                           k = k_item;
                        end else begin
                           k = tag_lookup(GRP_TOP, tag_next);
                           if (k == KIND_LIST)      lvl = 2'd1;
                           else if (k != KIND_NONE) lvl = 2'd0;
                        end
                     end
                     default: k = KIND_NONE;
                  endcase
                  if (k == KIND_NONE) begin
                     have          = 1'b1;
                     stop          = 1'b1;
                     rsp_in.tag    = tag_next;
                     rsp_in.kind   = KIND_END;
                     rsp_in.status = STAT_UNKNOWN;
                  end else begin
                     nest_in  = lvl;
                     acc_in   = {60'd0, k};
                     len_in   = '0;
                     phase_in = PH_LEN;
                  end
               end
            end
         endcase

         // End of a response: final flag, status and state reset.
         if (stop || last) begin
            rsp_in.final_flag = 1'b1;
         end
         if (!stop && last) begin
            if (!have) begin
               have        = 1'b1;
               rsp_in      = '0;
               rsp_in.tag  = tag_in;
               rsp_in.kind = KIND_END;
               rsp_in.final_flag = 1'b1;
            end
            rsp_in.status = (phase_in == PH_TAG && left_in == 32'd0) ? STAT_OK : STAT_TRUNC;
         end
         if (last) begin
            phase_in = PH_RTAG;
            tag_in   = '0;
            len_in   = '0;
            acc_in   = '0;
            left_in  = '0;
            mode_in  = MODE_NONE;
            nest_in  = 2'd0;
            halt_in  = 1'b0;
         end else if (stop) begin
            halt_in = 1'b1;
         end
      end

      valid_in = valid_ff && !out_ready;
      if (step && have) valid_in = 1'b1;
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RTAG;
         tag_ff   <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         mode_ff  <= MODE_NONE;
         nest_ff  <= 2'd0;
         halt_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            phase_ff <= phase_in;
            tag_ff   <= tag_in;
            len_ff   <= len_in;
            acc_ff   <= acc_in;
            left_ff  <= left_in;
            mode_ff  <= mode_in;
            nest_ff  <= nest_in;
            halt_ff  <= halt_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (step && have) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> tb/tb_dmap_tlv_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMAP TLV stream parser testbench
// Feeds DMAP response byte streams (well-formed responses with random content,
// truncated buffers, unknown tags, unsupported kinds and noise) and compares
// every result word with a local model of the parser, with random gaps and
// stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_dmap_tlv_stream_parser;
   import dmap_pkg::*;

   localparam int unsigned IDLE_LIMIT = 20000;

   // One expected or observed result word.
   typedef struct {
      logic [31:0] tag;
      logic [3:0]  kind;
      logic [63:0] value;
      logic        done;
      logic        empty;
      logic        in_record;
      logic        final_flag;
      logic [1:0]  status;
   } field_word_type;

   // Scoreboard: keeps the parser state and the queue of expected field words.
   class field_scoreboard;
      logic [3:0]  phase;
      logic [31:0] tag_sr;
      logic [31:0] len_sr;
      logic [63:0] accum;
      logic [31:0] count;
      logic [2:0]  mode;
      logic [1:0]  level;
      logic        halted;
      field_word_type pending[$];
      int          errors;

      function void clear();
         phase = PH_RTAG; tag_sr = 0; len_sr = 0; accum = 0; count = 0;
         mode = MODE_NONE; level = 0; halted = 0;
      endfunction

      function logic [3:0] classify(logic [31:0] t, ref logic [1:0] lv);
         logic [3:0] k;
         case (mode)
            MODE_SRV: return tag_lookup(GRP_SRV, t);
            MODE_LOG: return tag_lookup(GRP_LOG, t);
            MODE_UPD: return tag_lookup(GRP_UPD, t);
            MODE_LIST: ;
            default: return KIND_NONE;
         endcase
         if (lv != 0 && t == "mlit") begin
            lv = 2;
            return KIND_ITEM;
         end
         if (lv >= 2) begin
            k = tag_lookup(GRP_ITEM, t);
            if (k != KIND_NONE) return k;
         end
         k = tag_lookup(GRP_TOP, t);
         if (k == KIND_LIST) lv = 1;
         else if (k != KIND_NONE) lv = 0;
         return k;
      endfunction

      // Notes one accepted input byte and queues the field word it causes.
      function void note_byte(logic [7:0] b, logic last);
         field_word_type w;
         logic        have, stop;
         logic [3:0]  k;
         logic [1:0]  lv;
         have = 0; stop = 0;
         w = '{tag: 0, kind: 0, value: 0, done: 0, empty: 0, in_record: 0,
               final_flag: 0, status: STAT_OK};
         if (halted) begin
            if (last) clear();
            return;
         end
         case (phase)
            PH_RTAG: begin
               tag_sr = (count == 0) ? {24'd0, b} : {tag_sr[23:0], b};
               count++;
               if (count >= 4) begin
                  count = 0;
                  case (tag_sr)
                     "msrv": mode = MODE_SRV;
                     "mlog": mode = MODE_LOG;
                     "mupd": mode = MODE_UPD;
                     "adbs", "avdb", "apso", "aply": mode = MODE_LIST;
                     default: mode = MODE_NONE;
                  endcase
                  if (mode == MODE_NONE) begin
                     have = 1; stop = 1;
                     w.tag = tag_sr; w.kind = KIND_END; w.status = STAT_UNSUPP;
                  end else begin
                     phase = PH_RLEN;
                  end
               end
            end
            PH_RLEN: begin
               count++;
               if (count >= 4) begin
                  count = 0;
                  phase = PH_TAG;
               end
            end
            PH_LEN: begin
               len_sr = {len_sr[23:0], b};
               count++;
               if (count >= 4) begin
                  k = accum[3:0];
                  accum = 0; count = 0; phase = PH_TAG;
                  if (k == KIND_LIST || k == KIND_ITEM) begin
                     have = 1;
                     w.tag = tag_sr; w.kind = KIND_REC; w.in_record = (k == KIND_ITEM);
                  end else if (k == KIND_STR) begin
                     if (len_sr == 0) begin
                        have = 1;
                        w.tag = tag_sr; w.kind = KIND_STR; w.done = 1; w.empty = 1;
                        w.in_record = (level >= 2);
                     end else begin
                        count = len_sr;
                        phase = PH_STR;
                     end
                  end else if (k >= KIND_BYTE && k <= KIND_VER) begin
                     count = (k == KIND_BYTE) ? 1 : (k == KIND_SHORT) ? 2 :
                             (k == KIND_LONG) ? 8 : 4;
                     phase = PH_NUM + k;
                  end
               end
            end
            PH_NUM + KIND_BYTE, PH_NUM + KIND_SHORT, PH_NUM + KIND_INT,
            PH_NUM + KIND_LONG, PH_NUM + KIND_DATE, PH_NUM + KIND_VER: begin
               accum = {accum[55:0], b};
               if (count != 0) count--;
               if (count == 0) begin
                  have = 1;
                  w.tag = tag_sr; w.kind = phase - PH_NUM; w.value = accum;
                  w.in_record = (level >= 2);
                  accum = 0; phase = PH_TAG;
               end
            end
            PH_STR: begin
               have = 1;
               if (count != 0) count--;
               w.tag = tag_sr; w.kind = KIND_STR; w.value = {56'd0, b};
               w.done = (count == 0); w.in_record = (level >= 2);
               if (count == 0) phase = PH_TAG;
            end
            default: begin
               phase = PH_TAG;
               tag_sr = (count == 0) ? {24'd0, b} : {tag_sr[23:0], b};
               count++;
               if (count >= 4) begin
                  count = 0;
                  lv = level;
                  k = classify(tag_sr, lv);
                  if (k == KIND_NONE) begin
                     have = 1; stop = 1;
                     w.tag = tag_sr; w.kind = KIND_END; w.status = STAT_UNKNOWN;
                  end else begin
                     level = lv; accum = {60'd0, k}; len_sr = 0; phase = PH_LEN;
                  end
               end
            end
         endcase
         if (stop) begin
            if (last) clear();
            else halted = 1;
         end else if (last) begin
            if (!have) begin
               have = 1;
               w.tag = tag_sr; w.kind = KIND_END;
            end
            w.status = (phase == PH_TAG && count == 0) ? STAT_OK : STAT_TRUNC;
            clear();
         end
         if (have) begin
            w.final_flag = stop || last;
            pending.push_back(w);
         end
      endfunction

      // Compares one received word with the oldest expectation.
      function void check_word(field_word_type got);
         field_word_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word tag=%h kind=%0d", $time, got.tag, got.kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.tag !== e.tag || got.kind !== e.kind || got.value !== e.value ||
             got.done !== e.done || got.empty !== e.empty ||
             got.in_record !== e.in_record ||
             got.final_flag !== e.final_flag || got.status !== e.status) begin
            $display("%0t: mismatch expected tag=%h kind=%0d val=%h dn=%b em=%b in=%b fl=%b st=%0d",
                     $time, e.tag, e.kind, e.value, e.done, e.empty, e.in_record,
                     e.final_flag, e.status);
            $display("%0t:          actual tag=%h kind=%0d val=%h dn=%b em=%b in=%b fl=%b st=%0d",
                     $time, got.tag, got.kind, got.value, got.done, got.empty, got.in_record,
                     got.final_flag, got.status);
            errors++;
         end
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [7:0]    req_tdata = 0;
   logic          req_tlast = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [103:0]  rsp_tdata;
   logic [3:0]    rsp_tuser;
   logic          rsp_tlast;

   field_scoreboard sb;
   logic [7:0]  stream_bytes[$];
   int          idle_cycles = 0;
   int          hold_off = 0;
   bit          hold_go = 0;
   bit          hold_started = 0;

   always #10 clock = ~clock;

   dmap_tlv_stream_parser u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: random stalls plus one long hold-off, checks each accepted word.
   always @(posedge clock) begin
      field_word_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.tag = rsp_tdata[31:0];
            got.value = rsp_tdata[95:32];
            got.done = rsp_tdata[96];
            got.empty = rsp_tdata[97];
            got.in_record = rsp_tdata[98];
            got.status = rsp_tdata[100:99];
            got.kind = rsp_tuser;
            got.final_flag = rsp_tlast;
            sb.check_word(got);
         end
         if (hold_go && !hold_started) begin
            hold_started <= 1;
            hold_off <= 60;
            rsp_tready <= 0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70) ||
                          ($urandom_range(0, 3) == 0 && gap_len() == 0);
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("FAIL dmap_tlv_stream_parser");
         $finish;
      end
   end

   // Sends one byte and waits for it to be taken; valid drops only across a gap.
   task automatic send_byte(logic [7:0] b, logic last, bit no_gap);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, last);
   endtask

   // Sends the assembled byte list; the final byte carries tlast.
   task automatic send_stream(bit no_gap);
      int i;
      for (i = 0; i < stream_bytes.size(); i++) begin
         if (i == 0 || no_gap) send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1);
         else send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 0);
      end
      stream_bytes.delete();
   endtask

   function automatic void put32(logic [31:0] v);
      stream_bytes.push_back(v[31:24]); stream_bytes.push_back(v[23:16]);
      stream_bytes.push_back(v[15:8]);  stream_bytes.push_back(v[7:0]);
   endfunction

   function automatic logic [31:0] rand32();
      return $urandom();
   endfunction

   // Appends one element: numeric value of the given width, or a short string.
   function automatic void put_elem(logic [31:0] t, int nbytes, bit is_str);
      int n, i;
      n = is_str ? $urandom_range(0, 4) : nbytes;
      put32(t);
      put32(is_str ? n : rand32());
      for (i = 0; i < n; i++) stream_bytes.push_back($urandom_range(0, 255));
   endfunction

   function automatic int num_width(logic [3:0] k);
      return (k == KIND_BYTE) ? 1 : (k == KIND_SHORT) ? 2 : (k == KIND_LONG) ? 8 : 4;
   endfunction

   // Builds a random well-formed response, occasionally cut short or broken.
   function automatic void build_response();
      logic [31:0] srv_tags[17] = '{"mstt", "apro", "mpro", "mstm", "msix", "msex",
         "msup", "msal", "mslr", "msqy", "msrs", "msbr", "mspi", "msas", "msau",
         "aeSV", "minm"};
      logic [31:0] item_tags[12] = '{"miid", "mper", "minm", "mikd", "asbr", "asda",
         "asul", "asyr", "aeSP", "astm", "asdm", "agrp"};
      logic [31:0] top_tags[4] = '{"mstt", "muty", "mtco", "mrco"};
      logic [31:0] list_kinds[4] = '{"adbs", "avdb", "apso", "aply"};
      logic [31:0] t;
      logic [3:0]  k;
      int          sel, n, i, j, cut;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            put32("msrv"); put32(rand32());
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
               t = srv_tags[$urandom_range(0, 16)];
               k = tag_lookup(GRP_SRV, t);
               put_elem(t, num_width(k), k == KIND_STR);
            end
         end
         1: begin
            put32($urandom_range(0, 1) ? "mlog" : "mupd"); put32(rand32());
            put_elem("mstt", 4, 0);
            put_elem(stream_bytes[3] == "g" ? "mlid" : "musr", 4, 0);
         end
         9: begin
            if ($urandom_range(0, 1)) put32("mccr");
            else put32(rand32());
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) stream_bytes.push_back($urandom_range(0, 255));
         end
         default: begin
            put32(list_kinds[$urandom_range(0, 3)]); put32(rand32());
            t = top_tags[$urandom_range(0, 3)];
            put_elem(t, num_width(tag_lookup(GRP_TOP, t)), 0);
            put32("mlcl"); put32(rand32());
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
               put32("mlit"); put32(rand32());
               for (j = $urandom_range(1, 3); j > 0; j--) begin
                  t = item_tags[$urandom_range(0, 11)];
                  k = tag_lookup(GRP_ITEM, t);
                  put_elem(t, num_width(k), k == KIND_STR);
               end
            end
            if ($urandom_range(0, 2) == 0) put_elem("mrco", 4, 0);
         end
      endcase
      // Broken variants: cut short, or an unknown tag with trailing bytes.
      cut = $urandom_range(0, 9);
      if (cut == 0 && stream_bytes.size() > 2) begin
         n = $urandom_range(1, stream_bytes.size() - 1);
         while (stream_bytes.size() > n) void'(stream_bytes.pop_back());
      end else if (cut == 1 && sel != 9) begin
         put32("zzzz");
         for (i = $urandom_range(0, 5); i > 0; i--) stream_bytes.push_back($urandom_range(0, 255));
      end
   endfunction

   // Stimulus.
   initial begin
      int total;
      sb = new();
      sb.clear();
      sb.errors = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: server info with extreme values, a version and an empty string.
      put32("msrv"); put32(32'hFFFF_FFFF);
      put32("mpro"); put32(0); put32(32'hFFFF_0000);
      put32("msix"); put32(32'hFFFF_FFFF); stream_bytes.push_back(8'hFF);
      put32("minm"); put32(0);
      put32("mstt"); put32(7); put32(32'h0000_00C8);
      send_stream(0);
      // List response with long value and strings inside a record, then leave the list.
      put32("adbs"); put32(0);
      put32("mlcl"); put32(0);
      put32("mlit"); put32(0);
      put32("mper"); put32(0); put32(32'hFFFF_FFFF); put32(32'h0000_0000);
      put32("asul"); put32(2); stream_bytes.push_back(8'h00); stream_bytes.push_back(8'hFF);
      put32("mlit"); put32(0);
      put32("asbr"); put32(0); stream_bytes.push_back(8'h80); stream_bytes.push_back(8'h01);
      put32("mtco"); put32(0); put32(32'h8000_0001);
      send_stream(1);
      put32("mccr"); stream_bytes.push_back(8'h55); send_stream(0);
      put32("mlog"); put32(0); put32("mlid"); stream_bytes.push_back(8'h01); send_stream(0);
      put32("mupd"); put32(0); put32("abcd"); put32(0); send_stream(0);
      put32("apso"); put32(0); put32("mlit"); send_stream(0);
      stream_bytes.push_back(8'h6D); send_stream(0);

      // Long receiver hold-off while the sender keeps offering bytes.
      hold_go = 1;
      put32("msrv"); put32(0);
      put32("mstm"); put32(0); put32(rand32());
      put32("msdc"); put32(0); put32(rand32());
      send_stream(1);

      // Random responses; the directed part above is about 210 bytes.
      total = 0;
      while (total < 240) begin
         build_response();
         total += stream_bytes.size();
         send_stream($urandom_range(0, 4) == 0);
      end
      req_tvalid <= 0;

      // Drain, then allow the pipeline latency to settle.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("PASS dmap_tlv_stream_parser");
      else $display("FAIL dmap_tlv_stream_parser");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dmap_pkg.sv
hw/rtl/dmap_queue.sv
hw/rtl/dmap_core.sv
hw/rtl/dmap_tlv_stream_parser.sv
tb/tb_dmap_tlv_stream_parser.sv
